[hdl/dbse_pkg.sv]
// Shared types, codes and defaults for the de Boor spline sample evaluator.
`default_nettype none
package dbse_pkg;

  localparam int MAX_COEFFS_DEF = 32;
  localparam int MAX_DEGREE_DEF = 3;

  localparam int VALUE_SHIFT = 9;
  localparam logic signed [31:0] FAC_MAX = 32'sh7FFF_FFFF;

  localparam logic [1:0] CMD_COEF = 2'd0;
  localparam logic [1:0] CMD_KNOT = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_SUBINT = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [23:0]        sample_number;
  } item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic [23:0]        sample_echo;
    logic               in_period;
    logic               clipped;
  } result_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_RANGE, OP_TDIV, OP_SRCH_RD, OP_SRCH_CMP, OP_LOAD_RD, OP_LOAD_WR,
    OP_RD_LO, OP_RD_HI, OP_RD_R, OP_RD_L, OP_DIV1, OP_DIV2, OP_MUL1, OP_MUL2,
    OP_WR, OP_FIN_RD, OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    DIV_T, DIV_F1, DIV_F2
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    logic     take;
    logic     div_start;
    div_sel_t div_sel;
  } ctl_t;

  typedef struct packed {
    logic out_range;
    logic per_zero;
    logic div_done;
    logic srch_stop;
    logic load_last;
    logic den_zero;
    logic tri_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/dbse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dbse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/dbse_div.sv]
// Serial signed divider: trunc((num * 2^24) / den), saturated to +-(2^31-1).
`default_nettype none
module dbse_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [31:0] q
);
  import dbse_pkg::*;

  logic [33:0] mn;
  logic [33:0] md;
  logic        sat_now;
  logic        busy;
  logic [4:0]  cnt;
  logic [57:0] rem;
  logic [64:0] dsh;
  logic [31:0] qm;
  logic        neg;
  logic        sat;
  logic        ge;

  assign mn      = num[33] ? 34'(-num) : 34'(num);
  assign md      = den[33] ? 34'(-den) : 34'(den);
  assign sat_now = {7'b0, mn} >= {md, 7'b0};
  assign ge      = {7'b0, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[33] ^ den[33];
        sat <= sat_now;
        qm  <= '0;
        rem <= {mn, 24'b0};
        dsh <= {md, 31'b0};
        cnt <= 5'd31;
        if (sat_now) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh[57:0];
        end
        qm  <= {qm[30:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (sat) begin
      q = neg ? -FAC_MAX : FAC_MAX;
    end else begin
      q = neg ? -$signed(qm) : $signed(qm);
    end
  end

endmodule
`default_nettype wire

[hdl/dbse_dp.sv]
// Datapath: stores, span search, de Boor blend arithmetic and result register.
`default_nettype none
module dbse_dp #(
  parameter int MAX_COEFFS = dbse_pkg::MAX_COEFFS_DEF,
  parameter int MAX_DEGREE = dbse_pkg::MAX_DEGREE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dbse_pkg::ctl_t   ctl,
  output dbse_pkg::sts_t   sts,
  input  dbse_pkg::item_t  item,
  input  logic [1:0]       degree,
  input  logic [4:0]       subintervals,
  input  logic [31:0]      start_position,
  input  logic [23:0]      period_length,
  output logic             result_valid,
  input  logic             result_stall,
  output dbse_pkg::result_t result
);
  import dbse_pkg::*;

  localparam int KNOT_DEPTH = MAX_COEFFS + MAX_DEGREE + 1;
  localparam int ROW_DEPTH  = MAX_DEGREE + 1;
  localparam int CW = $clog2(MAX_COEFFS);
  localparam int KW = $clog2(KNOT_DEPTH);
  localparam int DW = $clog2(ROW_DEPTH);
  localparam int TW = 26;

  logic [23:0]           h;
  logic                  inper;
  logic [DW-1:0]         d;
  logic [CW-1:0]         last;
  logic [KW-1:0]         i;
  logic [CW-1:0]         kspan;
  logic [DW-1:0]         p;
  logic [DW-1:0]         jl;
  logic signed [TW-1:0]  t;
  logic signed [31:0]    lo;
  logic signed [31:0]    hi;
  logic signed [31:0]    right;
  logic signed [31:0]    left;
  logic                  zflag;
  logic signed [31:0]    f1;
  logic signed [31:0]    f2;
  logic signed [63:0]    prod1;
  logic signed [63:0]    prod2;

  logic [6:0]            idx7;
  logic                  coef_we;
  logic                  knot_we;
  logic [CW-1:0]         coef_raddr;
  logic [KW-1:0]         knot_raddr;
  logic [31:0]           coef_rdata;
  logic [31:0]           knot_rdata;
  logic                  row_we;
  logic [DW-1:0]         row_waddr;
  logic [DW-1:0]         row_raddr;
  logic [31:0]           row_wdata;
  logic [31:0]           row_rdata;

  logic [7:0]            dsel;
  logic [7:0]            ksel;
  logic [7:0]            lastsel;
  logic [31:0]           pos;
  logic [32:0]           pend;
  logic [31:0]           pdiff;
  logic                  out_range;

  logic signed [33:0]    tx;
  logic signed [33:0]    lox;
  logic signed [33:0]    hix;
  logic signed [33:0]    div_num;
  logic signed [33:0]    div_den;
  logic                  div_done;
  logic signed [31:0]    div_q;

  logic                  hit;
  logic                  srch_stop;
  logic [CW-1:0]         kc;
  logic [CW-1:0]         kfix;
  logic [KW:0]           jx;
  logic [DW-1:0]         j;
  logic [DW-1:0]         jm1;
  logic [KW-1:0]         hidx;
  logic [CW-1:0]         lb;
  logic                  tri_lo;

  logic signed [31:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [63:0]    mul_p;
  logic signed [64:0]    ssum;
  logic signed [40:0]    sfl;
  logic signed [31:0]    blend;

  logic signed [32:0]    xa;
  logic signed [32:0]    qv;
  logic                  clip;
  logic signed [15:0]    val16;
  logic                  out_free;

  assign idx7    = {1'b0, item.entry_index};
  assign coef_we = ctl.take && (item.command == CMD_COEF) && (idx7 < 7'(MAX_COEFFS));
  assign knot_we = ctl.take && (item.command == CMD_KNOT) && (idx7 < 7'(KNOT_DEPTH));

  dbse_ram #(.WIDTH(32), .DEPTH(MAX_COEFFS)) u_coef (
    .clk(clk), .we(coef_we), .waddr(idx7[CW-1:0]), .wdata(item.entry_value),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  dbse_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot (
    .clk(clk), .we(knot_we), .waddr(idx7[KW-1:0]), .wdata(item.entry_value),
    .raddr(knot_raddr), .rdata(knot_rdata)
  );

  dbse_ram #(.WIDTH(32), .DEPTH(ROW_DEPTH)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  always_comb begin
    dsel = {6'b0, degree};
    if (dsel == 8'd0) begin
      dsel = 8'd1;
    end
    if (dsel > 8'(MAX_DEGREE)) begin
      dsel = 8'(MAX_DEGREE);
    end
    if (dsel > 8'(MAX_COEFFS - 1)) begin
      dsel = 8'(MAX_COEFFS - 1);
    end
    ksel = {3'b0, subintervals};
    if (ksel == 8'd0) begin
      ksel = 8'd1;
    end
    if (ksel + dsel > 8'(MAX_COEFFS)) begin
      ksel = 8'(MAX_COEFFS) - dsel;
    end
    lastsel = ksel + dsel - 8'd1;
  end

  assign pos       = {h, 8'h00};
  assign pend      = {1'b0, start_position} + {9'b0, period_length};
  assign pdiff     = pos - start_position;
  assign out_range = (pos < start_position) || ({1'b0, pos} > pend);

  assign tx  = 34'(t);
  assign lox = 34'(lo);
  assign hix = 34'(hi);

  always_comb begin
    unique case (ctl.div_sel)
      DIV_F1: begin
        div_num = tx - lox;
        div_den = hix - lox;
      end
      DIV_F2: begin
        div_num = hix - tx;
        div_den = hix - lox;
      end
      default: begin
        div_num = $signed({2'b0, pdiff});
        div_den = $signed({10'b0, period_length});
      end
    endcase
  end

  dbse_div u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  assign hit       = 33'(tx) < 33'($signed(knot_rdata));
  assign srch_stop = hit || (i == KW'(last));
  assign kc        = hit ? CW'(i - KW'(1)) : last;
  assign kfix      = (kc < CW'(d)) ? CW'(d) : kc;

  assign jx     = (KW + 1)'(i) - ((KW + 1)'(kspan) - (KW + 1)'(d));
  assign j      = jx[DW-1:0];
  assign jm1    = j - DW'(1);
  assign hidx   = i + KW'(d) - KW'(p) + KW'(1);
  assign lb     = kspan - CW'(d) + CW'(p);
  assign tri_lo = (i == KW'(lb));

  assign coef_raddr = kspan - CW'(d) + CW'(jl);
  assign knot_raddr = (ctl.op == OP_RD_HI) ? hidx : i;

  always_comb begin
    unique case (ctl.op)
      OP_RD_HI: row_raddr = j;
      OP_RD_R:  row_raddr = jm1;
      default:  row_raddr = d;
    endcase
  end

  assign mul_a = (ctl.op == OP_MUL1) ? f1 : f2;
  assign mul_b = (ctl.op == OP_MUL1) ? right : left;
  assign mul_p = mul_a * mul_b;

  assign ssum = 65'(prod1) + 65'(prod2);
  assign sfl  = $signed(ssum[64:24]);

  always_comb begin
    if (sfl > 41'sd2147483647) begin
      blend = 32'sh7FFF_FFFF;
    end else if (sfl < -41'sd2147483648) begin
      blend = 32'sh8000_0000;
    end else begin
      blend = sfl[31:0];
    end
  end

  assign row_we    = (ctl.op == OP_LOAD_WR) || (ctl.op == OP_WR);
  assign row_waddr = (ctl.op == OP_LOAD_WR) ? jl : j;
  assign row_wdata = (ctl.op == OP_LOAD_WR) ? coef_rdata : (zflag ? 32'd0 : blend);

  assign xa   = 33'($signed(row_rdata)) +
                (row_rdata[31] ? 33'((1 << VALUE_SHIFT) - 1) : 33'sd0);
  assign qv   = xa >>> VALUE_SHIFT;
  assign clip = (qv > 33'sd32767) || (qv < -33'sd32768);
  assign val16 = clip ? (qv[32] ? -16'sd32768 : 16'sd32767) : qv[15:0];

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_IDLE: begin
        if (ctl.take && (item.command == CMD_EVAL)) begin
          h <= item.sample_number;
        end
      end
      OP_RANGE: begin
        d     <= DW'(dsel);
        last  <= CW'(lastsel);
        inper <= !out_range;
        i     <= KW'(1);
        t     <= '0;
      end
      OP_TDIV: begin
        if (div_done) begin
          t <= div_q[TW-1:0];
        end
      end
      OP_SRCH_CMP: begin
        if (srch_stop) begin
          kspan <= kfix;
          jl    <= '0;
        end else begin
          i <= i + KW'(1);
        end
      end
      OP_LOAD_WR: begin
        if (jl == d) begin
          p <= DW'(1);
          i <= KW'(kspan);
        end else begin
          jl <= jl + DW'(1);
        end
      end
      OP_RD_HI: lo <= knot_rdata;
      OP_RD_R: begin
        hi    <= knot_rdata;
        right <= row_rdata;
      end
      OP_RD_L: begin
        left  <= row_rdata;
        zflag <= (hi == lo);
      end
      OP_DIV1: begin
        if (div_done) begin
          f1 <= div_q;
        end
      end
      OP_DIV2: begin
        if (div_done) begin
          f2 <= div_q;
        end
      end
      OP_MUL1: prod1 <= mul_p;
      OP_MUL2: prod2 <= mul_p;
      OP_WR: begin
        if (tri_lo) begin
          p <= p + DW'(1);
          i <= KW'(kspan);
        end else begin
          i <= i - KW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((ctl.op == OP_OUT) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.op == OP_OUT) && out_free) begin
      result.sample_value <= inper ? val16 : 16'sd0;
      result.sample_echo  <= h;
      result.in_period    <= inper;
      result.clipped      <= inper && clip;
    end
  end

  always_comb begin
    sts.out_range = out_range;
    sts.per_zero  = (period_length == 24'd0);
    sts.div_done  = div_done;
    sts.srch_stop = srch_stop;
    sts.load_last = (jl == d);
    sts.den_zero  = (hi == lo);
    sts.tri_end   = tri_lo && (p == d);
    sts.out_free  = out_free;
  end

endmodule
`default_nettype wire

[hdl/dbse_ctrl.sv]
// Controller state machine sequencing load, search, blend and output steps.
`default_nettype none
module dbse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [1:0]     command,
  output logic           item_stall,
  output dbse_pkg::ctl_t ctl,
  input  dbse_pkg::sts_t sts
);
  import dbse_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE     = 18'd1 << 0,
    ST_RANGE    = 18'd1 << 1,
    ST_TDIV     = 18'd1 << 2,
    ST_SRCH_RD  = 18'd1 << 3,
    ST_SRCH_CMP = 18'd1 << 4,
    ST_LOAD_RD  = 18'd1 << 5,
    ST_LOAD_WR  = 18'd1 << 6,
    ST_RD_LO    = 18'd1 << 7,
    ST_RD_HI    = 18'd1 << 8,
    ST_RD_R     = 18'd1 << 9,
    ST_RD_L     = 18'd1 << 10,
    ST_DIV1     = 18'd1 << 11,
    ST_DIV2     = 18'd1 << 12,
    ST_MUL1     = 18'd1 << 13,
    ST_MUL2     = 18'd1 << 14,
    ST_WR       = 18'd1 << 15,
    ST_FIN_RD   = 18'd1 << 16,
    ST_OUT      = 18'd1 << 17
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    item_stall    = 1'b1;
    ctl.op        = OP_IDLE;
    ctl.take      = 1'b0;
    ctl.div_start = 1'b0;
    ctl.div_sel   = DIV_T;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        ctl.take   = item_valid;
        if (item_valid && (command == CMD_EVAL)) begin
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: begin
        ctl.op = OP_RANGE;
        if (sts.out_range) begin
          state_next = ST_OUT;
        end else if (sts.per_zero) begin
          state_next = ST_SRCH_RD;
        end else begin
          ctl.div_start = 1'b1;
          state_next    = ST_TDIV;
        end
      end
      ST_TDIV: begin
        ctl.op = OP_TDIV;
        if (sts.div_done) begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        ctl.op     = OP_SRCH_RD;
        state_next = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        ctl.op     = OP_SRCH_CMP;
        state_next = sts.srch_stop ? ST_LOAD_RD : ST_SRCH_RD;
      end
      ST_LOAD_RD: begin
        ctl.op     = OP_LOAD_RD;
        state_next = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        ctl.op     = OP_LOAD_WR;
        state_next = sts.load_last ? ST_RD_LO : ST_LOAD_RD;
      end
      ST_RD_LO: begin
        ctl.op     = OP_RD_LO;
        state_next = ST_RD_HI;
      end
      ST_RD_HI: begin
        ctl.op     = OP_RD_HI;
        state_next = ST_RD_R;
      end
      ST_RD_R: begin
        ctl.op     = OP_RD_R;
        state_next = ST_RD_L;
      end
      ST_RD_L: begin
        ctl.op      = OP_RD_L;
        ctl.div_sel = DIV_F1;
        if (sts.den_zero) begin
          state_next = ST_WR;
        end else begin
          ctl.div_start = 1'b1;
          state_next    = ST_DIV1;
        end
      end
      ST_DIV1: begin
        ctl.op      = OP_DIV1;
        ctl.div_sel = DIV_F2;
        if (sts.div_done) begin
          ctl.div_start = 1'b1;
          state_next    = ST_DIV2;
        end
      end
      ST_DIV2: begin
        ctl.op = OP_DIV2;
        if (sts.div_done) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        ctl.op     = OP_MUL1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.op     = OP_MUL2;
        state_next = ST_WR;
      end
      ST_WR: begin
        ctl.op     = OP_WR;
        state_next = sts.tri_end ? ST_FIN_RD : ST_RD_LO;
      end
      ST_FIN_RD: begin
        ctl.op     = OP_FIN_RD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        ctl.op = OP_OUT;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/de_boor_spline_sample_eval.sv]
// Top level of the de Boor spline sample evaluator with its register port.
// Load words are stored in the idle state, ready for the next word. An evaluate word runs
// the time divide, span search, row load and blends of two serial divides each; a zero
// period, zero-width knot interval or saturated factor cuts this short, and a result
// stall holds it. One word is worked on at a time. Reset clears control state and loads
// the register defaults; the stores hold no defined contents until written.
`default_nettype none
module de_boor_spline_sample_eval #(
  parameter int MAX_COEFFS = dbse_pkg::MAX_COEFFS_DEF,
  parameter int MAX_DEGREE = dbse_pkg::MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dbse_pkg::item_t   item_word,
  output logic              result_valid,
  input  logic              result_stall,
  output dbse_pkg::result_t result_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dbse_pkg::*;

  logic [1:0]  degree;
  logic [4:0]  subintervals;
  logic [31:0] start_position;
  logic [23:0] period_length;
  logic        reg_wr;
  ctl_t        ctl;
  sts_t        sts;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree         <= 2'd3;
      subintervals   <= 5'd20;
      start_position <= 32'd0;
      period_length  <= 24'd25088;
    end else if (reg_wr) begin
      unique case (paddr[3:2])
        REG_DEGREE: degree         <= pwdata[1:0];
        REG_SUBINT: subintervals   <= pwdata[4:0];
        REG_START:  start_position <= pwdata;
        REG_PERIOD: period_length  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEGREE: prdata = {30'd0, degree};
      REG_SUBINT: prdata = {27'd0, subintervals};
      REG_START:  prdata = start_position;
      REG_PERIOD: prdata = {8'd0, period_length};
      default:    prdata = 32'd0;
    endcase
  end

  dbse_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .command(item_word.command),
    .item_stall(item_stall), .ctl(ctl), .sts(sts)
  );

  dbse_dp #(.MAX_COEFFS(MAX_COEFFS), .MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .item(item_word),
    .degree(degree), .subintervals(subintervals),
    .start_position(start_position), .period_length(period_length),
    .result_valid(result_valid), .result_stall(result_stall), .result(result_word)
  );

endmodule
`default_nettype wire
